[rtl/core/pvu_pkg.sv]
// Package for the particle swarm velocity and position update block.
// Holds the fixed-point word types, register reset values, register
// indexes and the 16-bit saturation helper. No dependencies.
package pvu_pkg;

	// Signed Q8.8 value
	typedef logic signed [15:0] q88_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_INERTIA  = 2'd0,
		REG_COG_GAIN = 2'd1,
		REG_SOC_GAIN = 2'd2,
		REG_VEL_LIM  = 2'd3
	} pvu_reg_t;

	localparam logic [15:0] INERTIA_RST  = 16'd2986;
	localparam logic [15:0] COG_GAIN_RST = 16'd8192;
	localparam logic [15:0] SOC_GAIN_RST = 16'd8192;
	localparam logic [14:0] VEL_LIM_RST  = 15'd32767;

	// One input word as it enters the pipeline
	typedef struct packed {
		q88_t        velocity;
		q88_t        position;
		q88_t        pbest;
		q88_t        leader;
		logic [15:0] rnd_cog;
		logic [15:0] rnd_soc;
		q88_t        lower;
		q88_t        upper;
	} pvu_item_t;

	// Word after the velocity sum
	typedef struct packed {
		q88_t sum;
		q88_t position;
		q88_t lower;
		q88_t upper;
	} pvu_sum_t;

	// Word after constriction, clamp and position add
	typedef struct packed {
		q88_t              velocity;
		logic signed [16:0] position;
		q88_t              lower;
		q88_t              upper;
	} pvu_step_t;

	// Saturate a wide signed value to the Q8.8 range
	function automatic q88_t sat16(input logic signed [33:0] a);
		q88_t r;
		if (a > 34'sd32767) begin
			r = 16'sh7fff;
		end else if (a < -34'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = a[15:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/pvu_pull.sv]
// Pull stages: differences and random gains, pull products, velocity sum.
// Three pipeline stages with valid/ready per stage. Depends on pvu_pkg.
module pvu_pull (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pvu_pkg::pvu_item_t in_word,
	input  logic [15:0]        cognitive_gain,
	input  logic [15:0]        social_gain,
	output logic               out_valid,
	input  logic               out_ready,
	output pvu_pkg::pvu_sum_t  out_word
);
	import pvu_pkg::*;

	logic        vld_s1, vld_s2, vld_s3;
	logic        rdy_s1, rdy_s2, rdy_s3;

	// stage 1 payload
	q88_t        d1_s1, d2_s1, v_s1, x_s1, lo_s1, hi_s1;
	logic [15:0] k1_s1, k2_s1;
	// stage 2 payload
	logic signed [32:0] p1_s2, p2_s2;
	q88_t        v_s2, x_s2, lo_s2, hi_s2;
	// stage 3 payload
	pvu_sum_t    w_s3;

	logic [31:0] m1, m2;
	q88_t        d1, d2, t1, t2, a1;

	// A stage loads when empty or when its successor takes its word
	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: saturated differences and scaled random gains
	assign m1 = 32'(cognitive_gain) * 32'(in_word.rnd_cog);
	assign m2 = 32'(social_gain) * 32'(in_word.rnd_soc);
	assign d1 = sat16(34'(in_word.pbest) - 34'(in_word.position));
	assign d2 = sat16(34'(in_word.leader) - 34'(in_word.position));

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			d1_s1 <= d1;
			d2_s1 <= d2;
			k1_s1 <= m1[31:16];
			k2_s1 <= m2[31:16];
			v_s1  <= in_word.velocity;
			x_s1  <= in_word.position;
			lo_s1 <= in_word.lower;
			hi_s1 <= in_word.upper;
		end
	end

	// Stage 2: gain times difference
	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			p1_s2 <= 33'($signed({1'b0, k1_s1})) * 33'(d1_s1);
			p2_s2 <= 33'($signed({1'b0, k2_s1})) * 33'(d2_s1);
			v_s2  <= v_s1;
			x_s2  <= x_s1;
			lo_s2 <= lo_s1;
			hi_s2 <= hi_s1;
		end
	end

	// Stage 3: floor to Q8.8, saturate, accumulate with the old velocity
	assign t1 = sat16(34'(p1_s2 >>> 12));
	assign t2 = sat16(34'(p2_s2 >>> 12));
	assign a1 = sat16(34'(v_s2) + 34'(t1));

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			w_s3.sum      <= sat16(34'(a1) + 34'(t2));
			w_s3.position <= x_s2;
			w_s3.lower    <= lo_s2;
			w_s3.upper    <= hi_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_word  = w_s3;

endmodule

[rtl/core/pvu_constrict.sv]
// Constriction stages: scale the velocity sum, clamp it, add to position.
// Two pipeline stages with valid/ready per stage. Depends on pvu_pkg.
module pvu_constrict (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pvu_pkg::pvu_sum_t  in_word,
	input  logic [15:0]        inertia_factor,
	input  logic [14:0]        velocity_limit,
	output logic               out_valid,
	input  logic               out_ready,
	output pvu_pkg::pvu_step_t out_word
);
	import pvu_pkg::*;

	logic               vld_s4, vld_s5;
	logic               rdy_s4, rdy_s5;
	logic signed [32:0] prod_s4;
	q88_t               x_s4, lo_s4, hi_s4;
	pvu_step_t          w_s5;

	q88_t               u, u_c, lim, nlim;

	assign rdy_s5   = !vld_s5 || out_ready;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s4) vld_s4 <= in_valid;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// Stage 4: constriction product
	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			prod_s4 <= 33'($signed({1'b0, inertia_factor})) * 33'(in_word.sum);
			x_s4    <= in_word.position;
			lo_s4   <= in_word.lower;
			hi_s4   <= in_word.upper;
		end
	end

	// Stage 5: floor, saturate, clamp to the limit, form the new position
	assign lim  = $signed({1'b0, velocity_limit});
	assign nlim = -lim;
	assign u    = sat16(34'(prod_s4 >>> 12));

	always_comb begin
		if (u > lim) begin
			u_c = lim;
		end else if (u < nlim) begin
			u_c = nlim;
		end else begin
			u_c = u;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			w_s5.velocity <= u_c;
			w_s5.position <= 17'(x_s4) + 17'(u_c);
			w_s5.lower    <= lo_s4;
			w_s5.upper    <= hi_s4;
		end
	end

	assign out_valid = vld_s5;
	assign out_word  = w_s5;

endmodule

[rtl/core/pvu_bound.sv]
// Bound stage: pin the position to the bounds and bounce the velocity.
// One output register stage with valid/ready. Depends on pvu_pkg.
module pvu_bound (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pvu_pkg::pvu_step_t in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output pvu_pkg::q88_t      velocity,
	output pvu_pkg::q88_t      position,
	output logic               bounced
);
	import pvu_pkg::*;

	logic               vld_s6, rdy_s6;
	q88_t               v_s6, p_s6;
	logic               hit_s6;

	logic               lo_hit, hi_hit;
	logic signed [16:0] lo17, hi17, p1;
	q88_t               p2;

	assign rdy_s6   = !vld_s6 || out_ready;
	assign in_ready = rdy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (rdy_s6) begin
			vld_s6 <= in_valid;
		end
	end

	// Check the lower bound first, then the upper bound on the result
	assign lo17   = 17'(in_word.lower);
	assign hi17   = 17'(in_word.upper);
	assign lo_hit = in_word.position < lo17;
	assign p1     = lo_hit ? lo17 : in_word.position;
	assign hi_hit = p1 > hi17;
	assign p2     = hi_hit ? in_word.upper : p1[15:0];

	// Hold the result until the receiver takes it
	always_ff @(posedge clk) begin
		if (rdy_s6 && in_valid) begin
			v_s6   <= (lo_hit ^ hi_hit) ? -in_word.velocity : in_word.velocity;
			p_s6   <= p2;
			hit_s6 <= lo_hit | hi_hit;
		end
	end

	assign out_valid = vld_s6;
	assign velocity  = v_s6;
	assign position  = p_s6;
	assign bounced   = hit_s6;

endmodule

[rtl/core/pso_velocity_position_update_top.sv]
// Top level of the particle swarm velocity and position update block.
// Holds the configuration registers and chains pvu_pull, pvu_constrict
// and pvu_bound. Depends on pvu_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one particle dimension per
//   word: velocity, position, personal best, leader, two random factors
//   and the dimension's bounds. Output channel (out_valid/out_ready)
//   returns the new velocity, the new position and a bounce flag, one
//   word per input word, in order.
//   Six register stages, in order: gains and differences, pull products,
//   velocity sum, constriction product, clamp and position add, bounds.
//   One word is taken every cycle while the receiver does not stall.
//   Every stage has its own valid bit and loads when empty or when its
//   successor takes its word, so a stalled receiver fills the pipeline
//   and then drops in_ready; nothing is lost or repeated.
//   Configuration is to be written through cfg_we/cfg_index/cfg_data by
//   the user only while no word is in flight; the block does not enforce
//   this. Writes take effect at once.
//   Reset clears all valid bits and returns the registers to their
//   defaults (constriction 0.729, both gains 2.0, full velocity limit).
module pso_velocity_position_update_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   current_velocity,
	input  logic signed [15:0]   current_position,
	input  logic signed [15:0]   personal_best_position,
	input  logic signed [15:0]   leader_position,
	input  logic [15:0]          random_cognitive,
	input  logic [15:0]          random_social,
	input  logic signed [15:0]   lower_bound,
	input  logic signed [15:0]   upper_bound,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   new_velocity,
	output logic signed [15:0]   new_position,
	output logic                 bounced
);
	import pvu_pkg::*;

	logic [15:0] inertia_q, cog_gain_q, soc_gain_q;
	logic [14:0] vel_lim_q;

	pvu_item_t   item;
	pvu_sum_t    sum_word;
	pvu_step_t   step_word;
	logic        sum_valid, sum_ready, step_valid, step_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_q  <= INERTIA_RST;
			cog_gain_q <= COG_GAIN_RST;
			soc_gain_q <= SOC_GAIN_RST;
			vel_lim_q  <= VEL_LIM_RST;
		end else if (cfg_we) begin
			case (pvu_reg_t'(cfg_index))
				REG_INERTIA:  inertia_q  <= cfg_data;
				REG_COG_GAIN: cog_gain_q <= cfg_data;
				REG_SOC_GAIN: soc_gain_q <= cfg_data;
				REG_VEL_LIM:  vel_lim_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Pack the input word
	assign item.velocity = current_velocity;
	assign item.position = current_position;
	assign item.pbest    = personal_best_position;
	assign item.leader   = leader_position;
	assign item.rnd_cog  = random_cognitive;
	assign item.rnd_soc  = random_social;
	assign item.lower    = lower_bound;
	assign item.upper    = upper_bound;

	pvu_pull u_pull (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_word        (item),
		.cognitive_gain (cog_gain_q),
		.social_gain    (soc_gain_q),
		.out_valid      (sum_valid),
		.out_ready      (sum_ready),
		.out_word       (sum_word)
	);

	pvu_constrict u_constrict (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (sum_valid),
		.in_ready       (sum_ready),
		.in_word        (sum_word),
		.inertia_factor (inertia_q),
		.velocity_limit (vel_lim_q),
		.out_valid      (step_valid),
		.out_ready      (step_ready),
		.out_word       (step_word)
	);

	pvu_bound u_bound (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step_valid),
		.in_ready  (step_ready),
		.in_word   (step_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.velocity  (new_velocity),
		.position  (new_position),
		.bounced   (bounced)
	);

endmodule

[tb/pso_velocity_position_update_top_test.sv]
// Self-checking bench for pso_velocity_position_update_top: predicts each word
// with a fixed-point model of the velocity/position rule and compares in order.
// Depends on pvu_pkg and the block's RTL.
module pso_velocity_position_update_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pvu_pkg::*;

	localparam q88_t        Q_MAX       = 16'sh7fff;
	localparam q88_t        Q_MIN       = 16'sh8000;
	localparam logic [15:0] R_MAX       = 16'hffff;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          TAIL_CYCLES = 16;

	// One expected output word
	typedef struct packed {
		q88_t vel;
		q88_t pos;
		logic hit;
	} motion_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	pvu_item_t   in_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	q88_t        new_velocity;
	q88_t        new_position;
	logic        bounced;

	// Shadow copy of the configuration registers
	logic [15:0] inertia_q12 = INERTIA_RST;
	logic [15:0] cog_gain_q12 = COG_GAIN_RST;
	logic [15:0] soc_gain_q12 = SOC_GAIN_RST;
	logic [14:0] vel_limit_q8 = VEL_LIM_RST;

	motion_t motion_due[$];
	motion_t due;
	int      mismatch_count = 0;
	int      cycle_count = 0;
	bit      tx_idle = 1'b1;
	bit      rx_idle = 1'b1;
	int      rx_hold_cycles = 0;

	pso_velocity_position_update_top uut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_we                 (cfg_we),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.current_velocity       (in_word.velocity),
		.current_position       (in_word.position),
		.personal_best_position (in_word.pbest),
		.leader_position        (in_word.leader),
		.random_cognitive       (in_word.rnd_cog),
		.random_social          (in_word.rnd_soc),
		.lower_bound            (in_word.lower),
		.upper_bound            (in_word.upper),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.new_velocity           (new_velocity),
		.new_position           (new_position),
		.bounced                (bounced)
	);

	always #2 clk = ~clk;

	// Limit a wide value to the signed 16-bit range
	function automatic longint clip16(input longint a);
		if (a > 32767) return 32767;
		if (a < -32768) return -32768;
		return a;
	endfunction

	// Work out the new velocity, position and bounce flag of one dimension
	function automatic motion_t next_motion(input pvu_item_t w);
		longint  x, lo, hi, d_pb, d_ld, k_cog, k_soc, sum, vel, lim, pos;
		motion_t m;
		x = longint'($signed(w.position));
		lo = longint'($signed(w.lower));
		hi = longint'($signed(w.upper));
		d_pb = clip16(longint'($signed(w.pbest)) - x);
		d_ld = clip16(longint'($signed(w.leader)) - x);
		// gain times random factor, truncated back to Q4.12
		k_cog = (longint'(cog_gain_q12) * longint'(w.rnd_cog)) >>> 16;
		k_soc = (longint'(soc_gain_q12) * longint'(w.rnd_soc)) >>> 16;
		sum = clip16(longint'($signed(w.velocity)) + clip16((k_cog * d_pb) >>> 12));
		sum = clip16(sum + clip16((k_soc * d_ld) >>> 12));
		vel = clip16((longint'(inertia_q12) * sum) >>> 12);
		lim = longint'(vel_limit_q8);
		if (vel > lim) vel = lim;
		if (vel < -lim) vel = -lim;
		// pin to the lower bound first, then the upper one
		pos = x + vel;
		m.hit = 1'b0;
		if (pos < lo) begin
			pos = lo;
			vel = -vel;
			m.hit = 1'b1;
		end
		if (pos > hi) begin
			pos = hi;
			vel = -vel;
			m.hit = 1'b1;
		end
		m.vel = vel[15:0];
		m.pos = pos[15:0];
		return m;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 60) return 0;
		if (r < 92) return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 30));
	endfunction

	// Particle dimension: mostly bounded around the position, some crossed
	// bounds, some extremes, some raw noise
	function automatic pvu_item_t random_word();
		pvu_item_t w;
		int        sel, x;
		q88_t      swap;
		w = {$urandom(), $urandom(), $urandom(), $urandom()};
		sel = int'($urandom_range(0, 99));
		if (sel >= 25 && sel < 93) begin
			x = int'($urandom_range(0, 16000)) - 8000;
			w.position = 16'(x);
			w.velocity = 16'(int'($urandom_range(0, 4000)) - 2000);
			w.pbest = 16'(x + int'($urandom_range(0, 6000)) - 3000);
			w.leader = 16'(x + int'($urandom_range(0, 6000)) - 3000);
			w.lower = 16'(x - int'($urandom_range(0, 4000)));
			w.upper = 16'(x + int'($urandom_range(0, 4000)));
			if (sel >= 85) begin
				swap = w.lower;
				w.lower = w.upper;
				w.upper = swap;
			end
		end else if (sel >= 93) begin
			w.velocity = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
			w.position = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
			w.pbest = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
			w.leader = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
			w.rnd_cog = $urandom_range(0, 1) ? R_MAX : 16'h0000;
			w.rnd_soc = $urandom_range(0, 1) ? R_MAX : 16'h0000;
		end
		return w;
	endfunction

	// Register value: edges now and then, mostly realistic gains
	function automatic logic [15:0] random_reg_value();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			2, 3, 4, 5: return 16'($urandom_range(0, 16383));
			default: return 16'($urandom());
		endcase
	endfunction

	// Offer one word, optionally after a gap, and hold it until taken
	task automatic send_word(input pvu_item_t w);
		int gap;
		gap = tx_idle ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_word <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop offering and wait until every expected word is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (motion_due.size() != 0);
	endtask

	// Write one register while the pipeline is empty
	task automatic write_reg(input pvu_reg_t idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_INERTIA:  inertia_q12 = data;
			REG_COG_GAIN: cog_gain_q12 = data;
			REG_SOC_GAIN: soc_gain_q12 = data;
			REG_VEL_LIM:  vel_limit_q8 = data[14:0];
			default: ;
		endcase
	endtask

	// Field extremes, bounces on each side, crossed bounds, at reset settings
	task automatic test_directed_cases();
		send_word(pvu_item_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0, 16'h0, Q_MIN, Q_MAX});
		send_word(pvu_item_t'{Q_MAX, 16'sd0, 16'sd0, 16'sd0, 16'h0, 16'h0, Q_MIN, Q_MAX});
		send_word(pvu_item_t'{Q_MIN, 16'sd0, 16'sd0, 16'sd0, 16'h0, 16'h0, Q_MIN, Q_MAX});
		send_word(pvu_item_t'{16'sd0, Q_MIN, Q_MAX, Q_MAX, R_MAX, R_MAX, Q_MIN, Q_MAX});
		send_word(pvu_item_t'{16'sd0, Q_MAX, Q_MIN, Q_MIN, R_MAX, R_MAX, Q_MIN, Q_MAX});
		send_word(pvu_item_t'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, R_MAX, R_MAX, Q_MIN, Q_MAX});
		send_word(pvu_item_t'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, R_MAX, R_MAX, Q_MIN, Q_MAX});
		send_word(pvu_item_t'{-16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'h0, 16'h0,
			-16'sd100, 16'sd100});
		send_word(pvu_item_t'{16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'h0, 16'h0,
			-16'sd100, 16'sd100});
		send_word(pvu_item_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0, 16'h0,
			16'sd100, -16'sd100});
		send_word(pvu_item_t'{16'sd0, 16'sd200, 16'sd200, 16'sd200, 16'h0, 16'h0,
			16'sd100, -16'sd100});
		send_word(pvu_item_t'{16'sd0, -16'sd100, -16'sd100, -16'sd100, 16'h0, 16'h0,
			-16'sd100, 16'sd100});
		send_word(pvu_item_t'{16'sd0, 16'sd100, 16'sd100, 16'sd100, 16'h0, 16'h0,
			-16'sd100, 16'sd100});
		send_word(pvu_item_t'{16'sh5555, 16'sh2aaa, -16'sh1555, 16'sh0aaa, 16'haaaa,
			16'h5555, Q_MIN, Q_MAX});
		send_word(pvu_item_t'{16'sd300, 16'sd50, 16'sd0, 16'sd0, R_MAX, 16'h0,
			16'sd50, 16'sd50});
		send_word(pvu_item_t'{-16'sd4000, 16'sd0, 16'sd3000, -16'sd3000, 16'h8000,
			R_MAX, Q_MIN, Q_MAX});
	endtask

	// Sweep the registers through their extremes, including a zero limit
	task automatic test_register_extremes();
		wait_drained();
		write_reg(REG_INERTIA, 16'h0000);
		repeat (40) send_word(random_word());
		wait_drained();
		write_reg(REG_INERTIA, 16'hffff);
		write_reg(REG_COG_GAIN, 16'hffff);
		write_reg(REG_SOC_GAIN, 16'hffff);
		write_reg(REG_VEL_LIM, 16'hffff);
		repeat (40) send_word(random_word());
		wait_drained();
		write_reg(REG_VEL_LIM, 16'h0000);
		repeat (40) send_word(random_word());
		wait_drained();
		write_reg(REG_INERTIA, 16'h1000);
		write_reg(REG_COG_GAIN, 16'h0000);
		write_reg(REG_SOC_GAIN, 16'h0000);
		write_reg(REG_VEL_LIM, 16'h0100);
		repeat (40) send_word(random_word());
		wait_drained();
		write_reg(REG_INERTIA, INERTIA_RST);
		write_reg(REG_COG_GAIN, COG_GAIN_RST);
		write_reg(REG_SOC_GAIN, SOC_GAIN_RST);
		write_reg(REG_VEL_LIM, {1'b0, VEL_LIM_RST});
		repeat (40) send_word(random_word());
	endtask

	// Hold the receiver off while words keep coming, so the input stalls
	task automatic test_backpressure();
		wait_drained();
		tx_idle = 1'b0;
		rx_hold_cycles = 100;
		repeat (60) send_word(random_word());
		tx_idle = 1'b1;
	endtask

	// Random settings per phase, idling switched on and off between phases
	task automatic test_random_phases();
		for (int phase = 0; phase < 10; phase++) begin
			wait_drained();
			write_reg(REG_INERTIA, random_reg_value());
			write_reg(REG_COG_GAIN, random_reg_value());
			write_reg(REG_SOC_GAIN, random_reg_value());
			write_reg(REG_VEL_LIM, random_reg_value());
			tx_idle = (phase % 3) != 1;
			rx_idle = (phase % 4) != 2;
			repeat (120) send_word(random_word());
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Receiver: random stalls, a requested long hold-off, or always ready
	initial begin
		int stall;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold_cycles - 1) @(posedge clk);
				rx_hold_cycles = 0;
			end else begin
				stall = rx_idle ? pick_gap() : 0;
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall - 1) @(posedge clk);
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// Check each output word against the oldest expectation, then record
	// the expectation for any word taken at this edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (motion_due.size() == 0) begin
				$error("output word with nothing expected: vel %0d pos %0d bounced %0b",
					new_velocity, new_position, bounced);
				mismatch_count++;
			end else begin
				due = motion_due.pop_front();
				if (new_velocity !== due.vel) begin
					$error("new_velocity: expected %0d, got %0d", due.vel, new_velocity);
					mismatch_count++;
				end
				if (new_position !== due.pos) begin
					$error("new_position: expected %0d, got %0d", due.pos, new_position);
					mismatch_count++;
				end
				if (bounced !== due.hit) begin
					$error("bounced: expected %0b, got %0b", due.hit, bounced);
					mismatch_count++;
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			motion_due.insert(motion_due.size(), next_motion(in_word));
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("pso_velocity_position_update_top_test: errors");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_register_extremes();
		test_backpressure();
		test_random_phases();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && motion_due.size() == 0) begin
			$display("pso_velocity_position_update_top_test: clean");
		end else begin
			$display("pso_velocity_position_update_top_test: errors");
		end
		$finish;
	end

endmodule
